// ----- hw/rtl/rau_pkg.sv -----
package rau_pkg;

  localparam int DEF_PART_WIDTH = 32;

  // operation codes, bit 2 set means compare
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_WIDE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_EVEN,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    MS_P1,
    MS_P2,
    MS_DEN
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum_en;
    logic     even_shift;
    logic     gcd_load;
    logic     gcd_step;
    logic     div_init_n;
    logic     div_step;
    logic     div_end_n;
    logic     div_end_d;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic zerr;
    logic is_cmp;
    logic num_zero;
    logic both_even;
    logic u_zero;
  } sts_t;

endpackage

// ----- hw/rtl/rau_ctrl.sv -----
module rau_ctrl #(
  parameter int W = 2 * rau_pkg::DEF_PART_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd
);

  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  rau_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rau_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.mul_sel   = rau_pkg::MS_P1;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      rau_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rau_pkg::S_MUL1;
        end
      end
      rau_pkg::S_MUL1: begin
        if (sts.zerr) begin
          state_nxt = rau_pkg::S_FIN;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = rau_pkg::MS_P1;
          state_nxt   = rau_pkg::S_MUL2;
        end
      end
      rau_pkg::S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MS_P2;
        state_nxt   = rau_pkg::S_MUL3;
      end
      rau_pkg::S_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MS_DEN;
        state_nxt   = rau_pkg::S_SUM;
      end
      rau_pkg::S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = sts.is_cmp ? rau_pkg::S_FIN : rau_pkg::S_EVEN;
      end
      rau_pkg::S_EVEN: begin
        if (sts.num_zero) begin
          state_nxt = rau_pkg::S_FIN;
        end else if (sts.both_even) begin
          cmd.even_shift = 1'b1;
        end else begin
          cmd.gcd_load = 1'b1;
          state_nxt    = rau_pkg::S_GCD;
        end
      end
      rau_pkg::S_GCD: begin
        if (sts.u_zero) begin
          cmd.div_init_n = 1'b1;
          cnt_nxt        = CNT_LAST;
          state_nxt      = rau_pkg::S_DIVN;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      rau_pkg::S_DIVN: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          cmd.div_end_n = 1'b1;
          cnt_nxt       = CNT_LAST;
          state_nxt     = rau_pkg::S_DIVD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      rau_pkg::S_DIVD: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          cmd.div_end_d = 1'b1;
          state_nxt     = rau_pkg::S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      rau_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rau_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rau_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != rau_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/rau_dp.sv -----
module rau_dp #(
  parameter int P = rau_pkg::DEF_PART_WIDTH
) (
  input  logic               clk,
  input  logic        [2:0]  in_req_type,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic signed [31:0] out_res_num,
  output logic        [30:0] out_res_den,
  output logic               out_is_less,
  output logic               out_is_equal,
  output logic        [1:0]  out_status,
  input  rau_pkg::cmd_t      cmd,
  output rau_pkg::sts_t      sts
);

  localparam int W = 2 * P;
  localparam logic [W-1:0] LIM = W'(1) << (P - 1);

  logic [2:0]   op_r;
  logic         zerr_r;
  logic         an_neg_r, bn_neg_r;
  logic [P-1:0] an_r, ad_r, bn_r, bd_r;
  logic [W-1:0] p1_r, p2_r, den_r;
  logic         num_neg_r;
  logic [W-1:0] num_r;
  logic [W-1:0] u_r, v_r;
  logic [W-1:0] rem_r, quo_r;
  logic signed [31:0] res_num_r, res_num_nxt;
  logic [30:0]  res_den_r, res_den_nxt;
  logic         less_r, less_nxt, equal_r, equal_nxt;
  logic [1:0]   status_r, status_nxt;

  // operand split into sign and magnitude
  logic [P-1:0] an_raw, ad_raw, bn_raw, bd_raw;
  logic [P-1:0] an_mag, ad_mag, bn_mag, bd_mag;
  assign an_raw = in_a_num[P-1:0];
  assign ad_raw = in_a_den[P-1:0];
  assign bn_raw = in_b_num[P-1:0];
  assign bd_raw = in_b_den[P-1:0];
  assign an_mag = an_raw[P-1] ? (~an_raw + 1'b1) : an_raw;
  assign ad_mag = ad_raw[P-1] ? (~ad_raw + 1'b1) : ad_raw;
  assign bn_mag = bn_raw[P-1] ? (~bn_raw + 1'b1) : bn_raw;
  assign bd_mag = bd_raw[P-1] ? (~bd_raw + 1'b1) : bd_raw;

  logic is_cmp, is_prod;
  assign is_cmp  = op_r[2];
  assign is_prod = !op_r[2] && op_r[1];

  // shared multiplier
  logic [P-1:0] ma, mb;
  logic [W-1:0] prod;
  always_comb begin
    case (cmd.mul_sel)
      rau_pkg::MS_P1: begin
        ma = an_r;
        mb = (op_r == rau_pkg::OP_MUL) ? bn_r : bd_r;
      end
      rau_pkg::MS_P2: begin
        ma = bn_r;
        mb = ad_r;
      end
      rau_pkg::MS_DEN: begin
        ma = ad_r;
        mb = (op_r == rau_pkg::OP_DIV) ? bn_r : bd_r;
      end
      default: begin
        ma = an_r;
        mb = bd_r;
      end
    endcase
  end
  assign prod = ma * mb;

  // signed-magnitude sum of the two cross products, or the single product for mul and div
  logic         s1, s2, sum_neg;
  logic [W-1:0] sum_mag;
  assign s1 = an_neg_r ^ (is_prod & bn_neg_r);
  assign s2 = bn_neg_r ^ (is_cmp | (op_r == rau_pkg::OP_SUB));
  always_comb begin
    if (is_prod) begin
      sum_mag = p1_r;
      sum_neg = s1;
    end else if (s1 == s2) begin
      sum_mag = p1_r + p2_r;
      sum_neg = s1;
    end else if (p1_r >= p2_r) begin
      sum_mag = p1_r - p2_r;
      sum_neg = s1;
    end else begin
      sum_mag = p2_r - p1_r;
      sum_neg = s2;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  // restoring divide step, divisor is the odd gcd part
  logic [W:0]   trial;
  logic         qbit;
  logic [W-1:0] rem_nxt, quo_nxt;
  assign trial   = {rem_r, quo_r[W-1]};
  assign qbit    = (trial >= {1'b0, v_r});
  assign rem_nxt = qbit ? W'(trial - {1'b0, v_r}) : trial[W-1:0];
  assign quo_nxt = {quo_r[W-2:0], qbit};

  // result fields
  always_comb begin
    res_num_nxt = '0;
    res_den_nxt = '0;
    less_nxt    = 1'b0;
    equal_nxt   = 1'b0;
    status_nxt  = rau_pkg::ST_OK;
    if (zerr_r) begin
      status_nxt = rau_pkg::ST_ZDEN;
    end else if (is_cmp) begin
      less_nxt  = num_neg_r;
      equal_nxt = (num_r == '0);
    end else if (num_r == '0) begin
      res_den_nxt = 31'd1;
    end else if ((den_r > LIM - 1'b1) ||
                 (num_r > (num_neg_r ? LIM : LIM - 1'b1))) begin
      status_nxt = rau_pkg::ST_WIDE;
    end else begin
      res_num_nxt = num_neg_r ? (32'sd0 - $signed(32'(num_r))) : $signed(32'(num_r));
      res_den_nxt = 31'(den_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_req_type;
      zerr_r   <= (ad_mag == '0) || (bd_mag == '0) ||
                  ((in_req_type == rau_pkg::OP_DIV) && (bn_mag == '0));
      an_neg_r <= an_raw[P-1] ^ ad_raw[P-1];
      bn_neg_r <= bn_raw[P-1] ^ bd_raw[P-1];
      an_r     <= an_mag;
      ad_r     <= ad_mag;
      bn_r     <= bn_mag;
      bd_r     <= bd_mag;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        rau_pkg::MS_P1:  p1_r  <= prod;
        rau_pkg::MS_P2:  p2_r  <= prod;
        rau_pkg::MS_DEN: den_r <= prod;
        default:         p1_r  <= prod;
      endcase
    end
    if (cmd.sum_en) begin
      num_r     <= sum_mag;
      num_neg_r <= sum_neg;
    end
    if (cmd.even_shift) begin
      num_r <= num_r >> 1;
      den_r <= den_r >> 1;
    end
    if (cmd.gcd_load) begin
      u_r <= num_r;
      v_r <= den_r;
    end
    if (cmd.gcd_step) begin
      if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r >= v_r) begin
        u_r <= u_r - v_r;
      end else begin
        v_r <= v_r - u_r;
      end
    end
    if (cmd.div_init_n) begin
      rem_r <= '0;
      quo_r <= num_r;
    end else if (cmd.div_end_n) begin
      num_r <= quo_nxt;
      rem_r <= '0;
      quo_r <= den_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.div_end_d) begin
      den_r <= quo_nxt;
    end
    if (cmd.out_load) begin
      res_num_r <= res_num_nxt;
      res_den_r <= res_den_nxt;
      less_r    <= less_nxt;
      equal_r   <= equal_nxt;
      status_r  <= status_nxt;
    end
  end

  assign sts.zerr      = zerr_r;
  assign sts.is_cmp    = is_cmp;
  assign sts.num_zero  = (num_r == '0);
  assign sts.both_even = !num_r[0] && !den_r[0];
  assign sts.u_zero    = (u_r == '0);

  assign out_res_num  = res_num_r;
  assign out_res_den  = res_den_r;
  assign out_is_less  = less_r;
  assign out_is_equal = equal_r;
  assign out_status   = status_r;

endmodule

// ----- hw/rtl/rational_arithmetic_unit.sv -----
// timing: a zero denominator goes straight to the result, a compare ends after the sum,
//   a zero result after the factor-of-two check, otherwise it grows with each common
//   factor of two and each binary gcd step, then divides over W = 2*PART_WIDTH bits
// throughput: one request at a time, the next is taken in the cycle after the result
//   loads, later while a finished result waits under out_stall
// reset: rst_n synchronous active low, clears the state machine and out_valid
module rational_arithmetic_unit #(
  parameter int PART_WIDTH = rau_pkg::DEF_PART_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [2:0]  in_req_type,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res_num,
  output logic        [30:0] out_res_den,
  output logic               out_is_less,
  output logic               out_is_equal,
  output logic        [1:0]  out_status
);

  // flow: capture, three multiplies on one shared multiplier, signed sum,
  // strip common factors of two, odd binary gcd, then divide numerator and
  // denominator by the odd gcd one quotient bit a cycle

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl #(
    .W (2 * PART_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: operand registers, multiplier, gcd and divider
  rau_dp #(
    .P (PART_WIDTH)
  ) u_dp (
    .clk          (clk),
    .in_req_type  (in_req_type),
    .in_a_num     (in_a_num),
    .in_a_den     (in_a_den),
    .in_b_num     (in_b_num),
    .in_b_den     (in_b_den),
    .out_res_num  (out_res_num),
    .out_res_den  (out_res_den),
    .out_is_less  (out_is_less),
    .out_is_equal (out_is_equal),
    .out_status   (out_status),
    .cmd          (cmd),
    .sts          (sts)
  );

`ifndef SYNTH
  // a taken request keeps the unit busy the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("unit not busy after request");

  // error results carry a zero fraction
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != rau_pkg::ST_OK) |->
      (out_res_num == 32'sd0 && out_res_den == 31'd0 && !out_is_less && !out_is_equal))
    else $error("error result with nonzero payload");

  // compare flags exclusive and only with an empty fraction
  a_cmp_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_is_less || out_is_equal)) |->
      (!(out_is_less && out_is_equal) && out_res_den == 31'd0 &&
       out_status == rau_pkg::ST_OK))
    else $error("bad compare flags");
`endif

endmodule
